// ===== sv/pchl_pkg.sv =====
// Shared types and constants for the horizontal-line polygon clipper.
package pchl_pkg;

	localparam int COORD_BITS = 32;
	// magnitude of a coordinate difference needs one extra bit
	localparam int MAG_BITS = COORD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [MAG_BITS-1:0] mag_t;

	typedef struct packed {
		coord_t vertex_x;
		coord_t vertex_y;
		logic   final_vertex;
	} vertex_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		logic   is_vertex;
		logic   run_last;
	} result_t;

endpackage

// ===== sv/pchl_muldiv.sv =====
// Iterative unsigned multiply then divide, (a * b) / c, on one shared adder.
module pchl_muldiv import pchl_pkg::*; #(
	parameter int W = MAG_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] c,
	output logic         done,
	output logic [W-1:0] quo
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	logic [1:0]    phase_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  lo_q;
	logic          done_q;

	logic          div;
	logic [W+1:0]  op1;
	logic [W+1:0]  op2;
	logic [W+1:0]  sum;
	logic          qbit;

	// b and c must hold steady while the unit runs.
	// Mul: add b when the low multiplier bit is set, shift {acc, lo} right.
	// Div: restoring step, remainder in acc, dividend bits shift out of lo.
	always_comb begin
		div  = (phase_q == PH_DIV);
		op1  = div ? {1'b0, acc_q, lo_q[W-1]} : {2'b00, acc_q};
		op2  = div ? ~{2'b00, c} : (lo_q[0] ? {2'b00, b} : '0);
		sum  = op1 + op2 + {{(W+1){1'b0}}, div};
		qbit = ~sum[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= CW'(W - 1);
					end
				end
				PH_MUL: begin
					if (cnt_q == '0) begin
						phase_q <= PH_DIV;
						cnt_q   <= CW'(W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				PH_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				if (start) begin
					acc_q <= '0;
					lo_q  <= a;
				end
			end
			PH_MUL: begin
				acc_q <= sum[W:1];
				lo_q  <= {sum[0], lo_q[W-1:1]};
			end
			PH_DIV: begin
				acc_q <= qbit ? sum[W-1:0] : {acc_q[W-2:0], lo_q[W-1]};
				lo_q  <= {lo_q[W-2:0], qbit};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = lo_q;

endmodule

// ===== sv/polygon_clip_horizontal_line.sv =====
// An edge is evaluated in EVAL; its results are registered at the output in the emit states.
// Each emitted vertex or end marker waits in its emit state through any output stall.
// Each line crossing runs a multiply then a divide in the shared mul/div unit (MDGO, MD).
// One vertex at a time: in_stall holds off the next vertex until the sequencer is idle.
// Reset (arst_n low, async): sequencer idle, no vertex held, cut level 0, output empty.
module polygon_clip_horizontal_line import pchl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  vertex_t in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  coord_t  cfg_data
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EVAL     = 3'd1;
	localparam logic [2:0] ST_EMIT_S   = 3'd2;
	localparam logic [2:0] ST_MDGO     = 3'd3;
	localparam logic [2:0] ST_MD       = 3'd4;
	localparam logic [2:0] ST_EMIT_X   = 3'd5;
	localparam logic [2:0] ST_NEXT     = 3'd6;
	localparam logic [2:0] ST_EMIT_END = 3'd7;

	function automatic mag_t abs_mag(mag_t d);
		return d[MAG_BITS-1] ? (~d + 1'b1) : d;
	endfunction

	logic [2:0] state_q;
	coord_t     cut_q;
	logic       have_first_q;
	coord_t     first_x_q, first_y_q, prev_x_q, prev_y_q;
	coord_t     sx_q, sy_q, ex_q, ey_q;
	logic       fin_q, edge2_q;
	logic       cross_q, neg_q;
	mag_t       a_q, b_q, c_q;
	logic       out_valid_q;
	result_t    out_data_q;

	logic       accept;
	logic       out_free;
	logic       s_in, e_in;
	mag_t       da, db, dc;
	mag_t       md_quo;
	logic       md_done;
	logic       md_start;
	mag_t       xsum;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign md_start  = (state_q == ST_MDGO);

	always_comb begin
		s_in = (sy_q >= cut_q);
		e_in = (ey_q >= cut_q);
		da   = {cut_q[COORD_BITS-1], cut_q} - {sy_q[COORD_BITS-1], sy_q};
		db   = {ex_q[COORD_BITS-1], ex_q} - {sx_q[COORD_BITS-1], sx_q};
		dc   = {ey_q[COORD_BITS-1], ey_q} - {sy_q[COORD_BITS-1], sy_q};
		// quotient lies between 0 and |ex - sx|, so no overflow
		xsum = neg_q ? ({sx_q[COORD_BITS-1], sx_q} - md_quo)
		             : ({sx_q[COORD_BITS-1], sx_q} + md_quo);
	end

	pchl_muldiv #(
		.W(MAG_BITS)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.a     (a_q),
		.b     (b_q),
		.c     (c_q),
		.done  (md_done),
		.quo   (md_quo)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cut_q        <= '0;
			have_first_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cut_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						have_first_q <= !in_data.final_vertex;
						if (have_first_q || in_data.final_vertex) begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (s_in) begin
						state_q <= ST_EMIT_S;
					end else if (s_in != e_in) begin
						state_q <= ST_MDGO;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_EMIT_S: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= cross_q ? ST_MDGO : ST_NEXT;
					end
				end
				ST_MDGO: state_q <= ST_MD;
				ST_MD: begin
					if (md_done) begin
						state_q <= ST_EMIT_X;
					end
				end
				ST_EMIT_X: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (fin_q && !edge2_q) begin
						state_q <= ST_EVAL;
					end else if (fin_q) begin
						state_q <= ST_EMIT_END;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_END: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					prev_x_q <= in_data.vertex_x;
					prev_y_q <= in_data.vertex_y;
					fin_q    <= in_data.final_vertex;
					if (have_first_q) begin
						sx_q    <= prev_x_q;
						sy_q    <= prev_y_q;
						ex_q    <= in_data.vertex_x;
						ey_q    <= in_data.vertex_y;
						edge2_q <= 1'b0;
					end else begin
						// lone closing edge runs from the vertex to itself
						first_x_q <= in_data.vertex_x;
						first_y_q <= in_data.vertex_y;
						sx_q      <= in_data.vertex_x;
						sy_q      <= in_data.vertex_y;
						ex_q      <= in_data.vertex_x;
						ey_q      <= in_data.vertex_y;
						edge2_q   <= 1'b1;
					end
				end
			end
			ST_EVAL: begin
				cross_q <= (s_in != e_in);
				a_q     <= abs_mag(da);
				b_q     <= abs_mag(db);
				c_q     <= abs_mag(dc);
				neg_q   <= da[MAG_BITS-1] ^ db[MAG_BITS-1] ^ dc[MAG_BITS-1];
			end
			ST_EMIT_S: begin
				if (out_free) begin
					out_data_q.out_x     <= sx_q;
					out_data_q.out_y     <= sy_q;
					out_data_q.is_vertex <= 1'b1;
					out_data_q.run_last  <= !edge2_q && !fin_q && !cross_q;
				end
			end
			ST_EMIT_X: begin
				if (out_free) begin
					out_data_q.out_x     <= xsum[COORD_BITS-1:0];
					out_data_q.out_y     <= cut_q;
					out_data_q.is_vertex <= 1'b1;
					out_data_q.run_last  <= !edge2_q && !fin_q;
				end
			end
			ST_NEXT: begin
				if (fin_q && !edge2_q) begin
					// closing edge: last vertex back to the first
					edge2_q <= 1'b1;
					sx_q    <= ex_q;
					sy_q    <= ey_q;
					ex_q    <= first_x_q;
					ey_q    <= first_y_q;
				end
			end
			ST_EMIT_END: begin
				if (out_free) begin
					out_data_q.out_x     <= '0;
					out_data_q.out_y     <= '0;
					out_data_q.is_vertex <= 1'b0;
					out_data_q.run_last  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_done_in_md: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == ST_MD))
		else $error("mul/div finished outside the wait state");

	a_silent_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !have_first_q && !in_data.final_vertex) |=> (state_q == ST_IDLE))
		else $error("first vertex of a polygon started an edge");

	a_close_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.final_vertex) |=> !have_first_q)
		else $error("closing vertex left the polygon open");

	a_crossing_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_X) |-> cross_q)
		else $error("crossing emitted on an edge that does not cross");

endmodule

// ===== tb/pchl_clip_checker.sv =====
// Checker for the horizontal-line polygon clipper: predicts clipped vertices and compares.
module pchl_clip_checker
	import pchl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_stall,
	input  vertex_t in_data,
	input  logic    out_valid,
	input  logic    out_stall,
	input  result_t out_data,
	input  logic    cfg_valid,
	input  logic    cfg_ready,
	input  coord_t  cfg_data,
	output int      fail_count,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	coord_t cut_y;
	coord_t first_x, first_y, prev_x, prev_y;
	logic open_poly;
	result_t expected_pts[$];
	result_t emit[0:4];
	int n_emit;

	// x where the edge S->E meets the cut line; magnitude truncates toward zero
	function automatic coord_t cross_x(input coord_t sx, input coord_t sy,
		input coord_t ex, input coord_t ey, input coord_t cut);
		longint d_cut, d_x, d_y;
		logic [32:0] a, b, c;
		logic [65:0] prod, quot;
		logic neg;
		d_cut = longint'(cut) - longint'(sy);
		d_x = longint'(ex) - longint'(sx);
		d_y = longint'(ey) - longint'(sy);
		a = 33'((d_cut < 0) ? -d_cut : d_cut);
		b = 33'((d_x < 0) ? -d_x : d_x);
		c = 33'((d_y < 0) ? -d_y : d_y);
		neg = (d_cut < 0) ^ (d_x < 0) ^ (d_y < 0);
		prod = 66'(a) * 66'(b);
		quot = prod / 66'(c);
		return neg ? coord_t'(sx - quot[31:0]) : coord_t'(sx + quot[31:0]);
	endfunction

	task automatic add_point(input coord_t x, input coord_t y, input logic vtx);
		emit[n_emit] = {x, y, vtx, 1'b0};
		n_emit++;
	endtask

	task automatic clip_edge(input coord_t sx, input coord_t sy,
		input coord_t ex, input coord_t ey);
		logic s_in, e_in;
		s_in = (sy >= cut_y);
		e_in = (ey >= cut_y);
		if (s_in)
			add_point(sx, sy, 1'b1);
		if (s_in != e_in)
			add_point(cross_x(sx, sy, ex, ey, cut_y), cut_y, 1'b1);
	endtask

	task automatic predict_vertex(input vertex_t v);
		n_emit = 0;
		if (open_poly) begin
			clip_edge(prev_x, prev_y, v.vertex_x, v.vertex_y);
		end else begin
			first_x = v.vertex_x;
			first_y = v.vertex_y;
		end
		prev_x = v.vertex_x;
		prev_y = v.vertex_y;
		open_poly = 1'b1;
		if (v.final_vertex) begin
			clip_edge(v.vertex_x, v.vertex_y, first_x, first_y);
			add_point('0, '0, 1'b0);
			open_poly = 1'b0;
		end
		if (n_emit > 0)
			emit[n_emit-1].run_last = 1'b1;
		for (int i = 0; i < n_emit; i++)
			expected_pts.push_back(emit[i]);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_pts.size() == 0) begin
			$error("unexpected result x=%0d y=%0d is_vertex=%0b", got.out_x, got.out_y,
				got.is_vertex);
			fail_count++;
		end else begin
			want = expected_pts.pop_front();
			if (got.out_x !== want.out_x) begin
				$error("out_x expected %0d got %0d", want.out_x, got.out_x);
				fail_count++;
			end
			if (got.out_y !== want.out_y) begin
				$error("out_y expected %0d got %0d", want.out_y, got.out_y);
				fail_count++;
			end
			if (got.is_vertex !== want.is_vertex) begin
				$error("is_vertex expected %0b got %0b", want.is_vertex, got.is_vertex);
				fail_count++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last expected %0b got %0b", want.run_last, got.run_last);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_y = '0;
			first_x = '0;
			first_y = '0;
			prev_x = '0;
			prev_y = '0;
			open_poly = 1'b0;
			expected_pts.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cut_y = cfg_data;
			if (in_valid && !in_stall)
				predict_vertex(in_data);
			if (out_valid && !out_stall)
				check_result(out_data);
			pending <= expected_pts.size();
		end
	end

endmodule

// ===== tb/polygon_clip_horizontal_line_test.sv =====
// Testbench top for the horizontal-line polygon clipper: stimulus, stalls and verdict.
module polygon_clip_horizontal_line_test import pchl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam coord_t C_MAX = 32'sh7fff_ffff;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 180;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	vertex_t in_data;
	logic out_valid, out_stall;
	result_t out_data;
	logic cfg_valid, cfg_ready;
	coord_t cfg_data;
	int fail_count, pending;

	int hold_req;
	int burst_left;
	logic gaps_on;
	int items_sent;
	coord_t cur_cut;

	polygon_clip_horizontal_line u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	pchl_clip_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// receiver: stall density is redrawn at random from four levels, plus long hold-offs on request
	initial begin : rx_side
		int cyc, pct, hold_left, holds_seen;
		cyc = 0;
		pct = 0;
		hold_left = 0;
		holds_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_seen) begin
				holds_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (cyc % 64 == 0) begin
				case ($urandom_range(3))
					0: pct = 0;
					1: pct = 20;
					2: pct = 50;
					default: pct = 85;
				endcase
			end
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < pct);
			end
		end
	end

	task automatic send_vertex(input coord_t x, input coord_t y, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			gap = gaps_on ? $urandom_range(6, 0) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= {x, y, fin};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// let every expected point arrive, then let the sequencer settle
	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_cut(input coord_t level);
		wait_results();
		cfg_valid <= 1'b1;
		cfg_data <= level;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_cut = level;
	endtask

	function automatic coord_t pick_x();
		case ($urandom_range(9))
			0, 1, 2: return coord_t'($urandom);
			3: return $urandom_range(1) ? C_MAX : C_MIN;
			default: return coord_t'($urandom_range(32'h01ff_ffff)) - 32'sh00ff_ffff;
		endcase
	endfunction

	// mostly near the cut so edges cross it often
	function automatic coord_t pick_y(input coord_t cut);
		int unsigned off;
		off = $urandom_range(32'h00ff_ffff);
		case ($urandom_range(9))
			0, 1: return coord_t'($urandom);
			2: return cut;
			3: return $urandom_range(1) ? C_MAX : C_MIN;
			default: return $urandom_range(1) ? cut + coord_t'(off) : cut - coord_t'(off);
		endcase
	endfunction

	task automatic random_polygon();
		int n;
		n = ($urandom_range(9) == 0) ? 1 : $urandom_range(7, 2);
		for (int i = 0; i < n; i++)
			send_vertex(pick_x(), pick_y(cur_cut), i == n - 1);
	endtask

	task automatic random_phase(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			random_polygon();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_req = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		items_sent = 0;
		cur_cut = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cut at reset value: single-vertex polygons, inside and outside
		send_vertex(100, 200, 1'b1);
		send_vertex(100, -200, 1'b1);
		// crossing upward, then downward on the closing edge
		send_vertex(0, -100, 1'b0);
		send_vertex(100, 100, 1'b0);
		send_vertex(-100, 100, 1'b1);
		// vertex on the line counts inside; vertical edges
		send_vertex(7, 0, 1'b0);
		send_vertex(7, -50, 1'b0);
		send_vertex(7, 50, 1'b1);
		// fully outside: middle items give nothing
		send_vertex(0, -1, 1'b0);
		send_vertex(10, -1, 1'b0);
		send_vertex(10, -10, 1'b0);
		send_vertex(0, -10, 1'b1);
		// full-range coordinates
		send_vertex(C_MIN, C_MIN, 1'b0);
		send_vertex(C_MAX, C_MAX, 1'b0);
		send_vertex(C_MAX, C_MIN, 1'b1);
		set_cut(C_MAX);
		send_vertex(0, C_MAX, 1'b0);
		send_vertex(5, C_MIN, 1'b1);
		set_cut(C_MIN);
		send_vertex(C_MIN, C_MIN, 1'b0);
		send_vertex(C_MAX, C_MAX, 1'b1);
		set_cut(-12345);
		send_vertex(3, -20000, 1'b0);
		send_vertex(-77, 40000, 1'b0);
		send_vertex(1000, -12346, 1'b1);

		set_cut('0);
		random_phase(RANDOM_ITEMS / 6);

		// receiver holds off while the sender keeps offering
		set_cut(coord_t'($urandom));
		gaps_on = 1'b0;
		random_phase(6);
		hold_req <= hold_req + 1;
		random_phase(RANDOM_ITEMS / 6);
		gaps_on = 1'b1;

		set_cut(C_MIN);
		random_phase(RANDOM_ITEMS / 6);

		set_cut(C_MAX);
		random_phase(RANDOM_ITEMS / 6);

		// sender pauses until every point is out
		set_cut(coord_t'($urandom_range(32'h0002_0000)) - 32'sh0001_0000);
		random_phase(RANDOM_ITEMS / 12);
		wait_results();
		random_phase(RANDOM_ITEMS / 12);

		set_cut(coord_t'($urandom));
		random_phase(RANDOM_ITEMS / 6);

		wait_results();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
